### hw/rtl/itrp_pkg.sv
// Package for the indexed table: payload structs, op and status codes,
// controller states and the command/status structs between controller and datapath.
package itrp_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned EntryWidthDefault = 32;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_READ    = 3'd3,
    OP_SEARCH  = 3'd4,
    OP_COMPACT = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_SHIFT = 2'd0,
    POL_MOVE  = 2'd1,
    POL_HOLE  = 2'd2,
    POL_BAD   = 2'd3
  } policy_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_HSCAN,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_MV_RD,
    S_MV_WR,
    S_SRCH,
    S_CMP_RD,
    S_CMP_WR,
    S_CLR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  position;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        slot_used;
    logic [5:0]  found_position;
    logic [6:0]  fill_count;
    logic [6:0]  hole_count;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic set_idx_pos;
    logic set_idx_zero;
    logic set_idx_fill;   // idx = fill
    logic set_idx_tgt;    // idx = target
    logic idx_inc;
    logic idx_dec;
    logic tgt_from_idx;
    logic tgt_from_fill;
    logic rd_idx;         // memory read at idx
    logic rd_idx_m1;      // memory read at idx-1
    logic rd_idx_p1;      // memory read at idx+1
    logic rd_last;        // memory read at fill-1
    logic rd_pos;         // memory read at pos
    logic rd_zero;        // memory read at entry 0
    logic wr_idx_rdata;   // write read data/occ to idx
    logic wr_pos_val;     // write item value to pos, occupied
    logic wr_fill_val;    // append
    logic wr_j_rdata;     // compact move
    logic j_inc;
    logic j_zero;
    logic clr_occ_idx;    // clear occupied at idx-1
    logic clr_occ_all;
    logic fill_inc;
    logic fill_dec;
    logic fill_from_j;
    logic hole_inc;
    logic hole_dec;
    logic hole_zero;
    logic clr_occ_last;   // clear occ at fill-1 (before fill_dec)
    logic clr_occ_pos;
    logic res_set;
    logic [1:0] res_status;
    logic res_read;
    logic res_found;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_gt_fill;
    logic       pos_ge_fill;
    logic       pos_occ;
    logic       full;
    logic       holes;
    logic       idx_lt_fill;   // idx < fill
    logic       idx_gt_pos;
    logic       idx_p1_lt_fill;
    logic       idx_occ;
    logic       idx_match;     // occupied and equal
    logic       rocc;          // occupied bit of last read
    logic       idx_ne_j;
    logic       idx_last;      // idx == depth-1
  } dp_stat_t;

endpackage

### hw/rtl/indexed_table_with_remove_policies.sv
// Top level of the indexed table with selectable remove policies.
// Instantiates itrp_ctrl and itrp_datapath; depends on itrp_pkg.
//
// One item is accepted when start is high and busy is low; its single result
// appears on result_o for one cycle with done_o high, and cannot be stalled.
// Busy drops in the cycle that carries the result, so the next item can be
// accepted there. Append, clear, hole remove and rejected items pass through
// the decide and done states only; read also passes the search state, and
// move remove its read and write states. Insert and order-keeping remove
// spend a read and a write state per moved entry; search compares one entry
// per cycle. Insert that scans for a hole and compact, which also clears the
// freed occupied bits, walk the table further. Fill count and position set
// how long each of these takes.
module indexed_table_with_remove_policies import itrp_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned EntryWidth = EntryWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic [1:0] policy_q;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_SHIFT;
    end else if (cfg_we_i) begin
      policy_q <= cfg_wdata_i;
    end
  end

  itrp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .policy_i (policy_q),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  itrp_datapath #(
    .TableDepth (TableDepth),
    .EntryWidth (EntryWidth)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

### hw/rtl/itrp_datapath.sv
// Datapath of the indexed table: entry memory, occupied bits, counters,
// walk index and result register. Depends on itrp_pkg.
module itrp_datapath import itrp_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned EntryWidth = EntryWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output out_item_t result_o,
  output logic      done_o
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);

  logic [EntryWidth-1:0] mem_q [TableDepth];
  logic [TableDepth-1:0] occ_q;
  logic [EntryWidth-1:0] rdata_q;
  logic                  rocc_q;
  logic [CW-1:0] fill_q, hole_q;
  logic [CW-1:0] idx_q, tgt_q, j_q;
  logic [2:0]    op_q;
  logic [CW-1:0] pos_q;
  logic [EntryWidth-1:0] val_q;
  out_item_t res_q;
  logic      done_q;

  logic [CW-1:0] idx_m1, idx_p1, last;
  logic [AW-1:0] raddr;
  logic          rd_en;

  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign last   = fill_q - CW'(1);

  always_comb begin
    rd_en = 1'b1;
    if (cmd_i.rd_idx_m1) begin
      raddr = idx_m1[AW-1:0];
    end else if (cmd_i.rd_idx_p1) begin
      raddr = idx_p1[AW-1:0];
    end else if (cmd_i.rd_last) begin
      raddr = last[AW-1:0];
    end else if (cmd_i.rd_idx) begin
      raddr = idx_q[AW-1:0];
    end else if (cmd_i.rd_pos) begin
      raddr = pos_q[AW-1:0];
    end else if (cmd_i.rd_zero) begin
      raddr = '0;
    end else begin
      raddr = pos_q[AW-1:0];
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
    if (cmd_i.wr_idx_rdata) begin
      mem_q[idx_q[AW-1:0]] <= rdata_q;
    end else if (cmd_i.wr_j_rdata) begin
      mem_q[j_q[AW-1:0]] <= rdata_q;
    end else if (cmd_i.wr_pos_val) begin
      mem_q[pos_q[AW-1:0]] <= val_q;
    end else if (cmd_i.wr_fill_val) begin
      mem_q[fill_q[AW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      fill_q <= '0;
      hole_q <= '0;
      idx_q  <= '0;
      tgt_q  <= '0;
      j_q    <= '0;
      op_q   <= '0;
      pos_q  <= '0;
      rocc_q <= 1'b0;
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      if (rd_en) begin
        rocc_q <= occ_q[raddr];
      end
      if (cmd_i.load) begin
        op_q  <= item_i.op;
        pos_q <= CW'(item_i.position);
      end
      if (cmd_i.set_idx_pos) begin
        idx_q <= pos_q;
      end else if (cmd_i.set_idx_zero) begin
        idx_q <= '0;
      end else if (cmd_i.set_idx_fill) begin
        idx_q <= fill_q;
      end else if (cmd_i.set_idx_tgt) begin
        idx_q <= tgt_q;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_p1;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.tgt_from_idx) begin
        tgt_q <= idx_q;
      end else if (cmd_i.tgt_from_fill) begin
        tgt_q <= fill_q;
      end
      if (cmd_i.j_zero) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CW'(1);
      end
      if (cmd_i.wr_idx_rdata) begin
        occ_q[idx_q[AW-1:0]] <= rocc_q;
      end else if (cmd_i.wr_j_rdata) begin
        occ_q[j_q[AW-1:0]] <= rocc_q;
      end else if (cmd_i.wr_pos_val) begin
        occ_q[pos_q[AW-1:0]] <= 1'b1;
      end else if (cmd_i.wr_fill_val) begin
        occ_q[fill_q[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.clr_occ_all) begin
        occ_q <= '0;
      end else if (cmd_i.clr_occ_idx) begin
        occ_q[idx_m1[AW-1:0]] <= 1'b0;
      end else if (cmd_i.clr_occ_last) begin
        occ_q[last[AW-1:0]] <= 1'b0;
      end else if (cmd_i.clr_occ_pos) begin
        occ_q[pos_q[AW-1:0]] <= 1'b0;
      end
      if (cmd_i.fill_from_j) begin
        fill_q <= j_q;
      end else if (cmd_i.fill_inc) begin
        fill_q <= fill_q + CW'(1);
      end else if (cmd_i.fill_dec) begin
        fill_q <= last;
      end else if (cmd_i.clr_occ_all) begin
        fill_q <= '0;
      end
      if (cmd_i.hole_zero) begin
        hole_q <= '0;
      end else if (cmd_i.hole_inc) begin
        hole_q <= hole_q + CW'(1);
      end else if (cmd_i.hole_dec) begin
        hole_q <= hole_q - CW'(1);
      end
      done_q <= cmd_i.emit;
      if (cmd_i.res_set) begin
        res_q.status         <= cmd_i.res_status;
        res_q.read_value     <= cmd_i.res_read ? 32'(rdata_q) : '0;
        res_q.slot_used      <= cmd_i.res_read;
        res_q.found_position <= cmd_i.res_found ? 6'(idx_q) : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= EntryWidth'(item_i.entry_value);
    end
  end

  always_comb begin
    result_o            = res_q;
    result_o.fill_count = 7'(fill_q);
    result_o.hole_count = 7'(hole_q);
  end
  assign done_o = done_q;

  assign stat_o.op             = op_q;
  assign stat_o.pos_gt_fill    = pos_q > fill_q;
  assign stat_o.pos_ge_fill    = pos_q >= fill_q;
  assign stat_o.pos_occ        = occ_q[pos_q[AW-1:0]];
  assign stat_o.full           = fill_q >= CW'(TableDepth);
  assign stat_o.holes          = hole_q != '0;
  assign stat_o.idx_lt_fill    = idx_q < fill_q;
  assign stat_o.idx_gt_pos     = idx_q > pos_q;
  assign stat_o.idx_p1_lt_fill = idx_p1 < fill_q;
  assign stat_o.idx_occ        = occ_q[idx_q[AW-1:0]];
  assign stat_o.idx_match      = rocc_q && (rdata_q == val_q);
  assign stat_o.rocc           = rocc_q;
  assign stat_o.idx_ne_j       = idx_q != j_q;
  assign stat_o.idx_last       = idx_q == CW'(TableDepth - 1);

  property p_hole_le_fill;
    @(posedge clk_i) disable iff (!rst_ni) hole_q <= fill_q;
  endproperty
  a_hole_le_fill: assert property (p_hole_le_fill) else $error("hole count above fill");

  property p_fill_range;
    @(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(TableDepth);
  endproperty
  a_fill_range: assert property (p_fill_range) else $error("fill count out of range");

  property p_one_write;
    @(posedge clk_i) disable iff (!rst_ni)
      $onehot0({cmd_i.wr_idx_rdata, cmd_i.wr_j_rdata, cmd_i.wr_pos_val, cmd_i.wr_fill_val});
  endproperty
  a_one_write: assert property (p_one_write) else $error("multiple memory writes");

endmodule

### hw/rtl/itrp_ctrl.sv
// Controller state machine of the indexed table: sequences each item over
// the datapath one entry at a time. Depends on itrp_pkg.
module itrp_ctrl import itrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic [1:0] policy_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  state_e state_q, state_d;
  logic   reuse_q, reuse_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      reuse_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reuse_q <= reuse_d;
    end
  end

  always_comb begin
    state_d = state_q;
    reuse_d = reuse_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        case (op_e'(stat_i.op))
          OP_INSERT: begin
            reuse_d = 1'b0;
            if (!stat_i.pos_gt_fill) begin
              if (stat_i.holes) begin
                state_d = S_HSCAN;
              end else if (!stat_i.full) begin
                state_d = S_SHUP_RD;
              end
            end
          end
          OP_REMOVE: begin
            if (!stat_i.pos_ge_fill && stat_i.pos_occ) begin
              if (policy_e'(policy_i) == POL_SHIFT) begin
                state_d = S_SHDN_RD;
              end else if (policy_e'(policy_i) == POL_MOVE) begin
                state_d = S_MV_RD;
              end
            end
          end
          OP_SEARCH:  state_d = S_SRCH;
          OP_COMPACT: state_d = S_CMP_RD;
          OP_READ:    state_d = S_SRCH;
          default:    state_d = S_DONE;
        endcase
      end
      S_HSCAN: begin
        if (!stat_i.idx_lt_fill) begin
          state_d = stat_i.full ? S_DONE : S_SHUP_RD;
        end else if (!stat_i.idx_occ) begin
          reuse_d = 1'b1;
          state_d = S_SHUP_RD;
        end
      end
      S_SHUP_RD: state_d = stat_i.idx_gt_pos ? S_SHUP_WR : S_DONE;
      S_SHUP_WR: state_d = S_SHUP_RD;
      S_SHDN_RD: state_d = stat_i.idx_p1_lt_fill ? S_SHDN_WR : S_DONE;
      S_SHDN_WR: state_d = S_SHDN_RD;
      S_MV_RD:   state_d = S_MV_WR;
      S_MV_WR:   state_d = S_DONE;
      S_SRCH: begin
        if (op_e'(stat_i.op) == OP_READ) begin
          state_d = S_DONE;
        end else if (!stat_i.idx_lt_fill) begin
          state_d = S_DONE;
        end else if (stat_i.idx_match) begin
          state_d = S_DONE;
        end
      end
      S_CMP_RD: state_d = stat_i.idx_lt_fill ? S_CMP_WR : S_CLR;
      S_CMP_WR: state_d = S_CMP_RD;
      S_CLR:    state_d = stat_i.idx_ne_j ? S_CLR : S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // The search state is entered with the first read already issued; each
  // cycle compares the read data for idx and issues the read for idx+1.
  always_comb begin
    cmd_o = '0;
    busy  = state_q != S_IDLE;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_DECIDE: begin
        cmd_o.set_idx_pos = 1'b1;
        case (op_e'(stat_i.op))
          OP_APPEND: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.wr_fill_val = 1'b1;
              cmd_o.fill_inc    = 1'b1;
            end
          end
          OP_INSERT: begin
            cmd_o.tgt_from_fill = 1'b1;
            cmd_o.res_set       = 1'b1;
            if (stat_i.pos_gt_fill) begin
              cmd_o.res_status = ST_BAD_POS;
            end else if (stat_i.holes) begin
              cmd_o.res_status = ST_OK;
            end else if (stat_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.set_idx_pos  = 1'b0;
              cmd_o.set_idx_fill = 1'b1;
            end
          end
          OP_REMOVE: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.pos_ge_fill || !stat_i.pos_occ || policy_e'(policy_i) == POL_BAD) begin
              cmd_o.res_status = ST_BAD_POS;
            end else if (policy_e'(policy_i) == POL_HOLE) begin
              cmd_o.clr_occ_pos = 1'b1;
              cmd_o.hole_inc    = 1'b1;
            end else if (policy_e'(policy_i) == POL_MOVE) begin
              cmd_o.rd_last = 1'b1;
            end
          end
          OP_READ: begin
            cmd_o.rd_pos = 1'b1;
          end
          OP_SEARCH: begin
            cmd_o.set_idx_pos  = 1'b0;
            cmd_o.set_idx_zero = 1'b1;
            cmd_o.rd_zero      = 1'b1;
          end
          OP_COMPACT: begin
            cmd_o.set_idx_pos  = 1'b0;
            cmd_o.set_idx_zero = 1'b1;
            cmd_o.j_zero       = 1'b1;
          end
          OP_CLEAR: begin
            cmd_o.clr_occ_all = 1'b1;
            cmd_o.hole_zero   = 1'b1;
            cmd_o.res_set     = 1'b1;
          end
          default: begin
            cmd_o.res_set = 1'b1;
          end
        endcase
      end
      S_HSCAN: begin
        if (!stat_i.idx_lt_fill) begin
          if (stat_i.full) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_FULL;
          end else begin
            cmd_o.set_idx_fill = 1'b1;
          end
        end else if (!stat_i.idx_occ) begin
          cmd_o.tgt_from_idx = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SHUP_RD: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.rd_idx_m1 = 1'b1;
        end else begin
          cmd_o.wr_pos_val = 1'b1;
          cmd_o.res_set    = 1'b1;
          if (reuse_q) begin
            cmd_o.hole_dec = 1'b1;
          end else begin
            cmd_o.fill_inc = 1'b1;
          end
        end
      end
      S_SHUP_WR: begin
        cmd_o.wr_idx_rdata = 1'b1;
        cmd_o.idx_dec      = 1'b1;
      end
      S_SHDN_RD: begin
        if (stat_i.idx_p1_lt_fill) begin
          cmd_o.rd_idx_p1 = 1'b1;
        end else begin
          cmd_o.clr_occ_last = 1'b1;
          cmd_o.fill_dec     = 1'b1;
        end
      end
      S_SHDN_WR: begin
        cmd_o.wr_idx_rdata = 1'b1;
        cmd_o.idx_inc      = 1'b1;
      end
      S_MV_RD: begin
        cmd_o.wr_idx_rdata = 1'b1;
      end
      S_MV_WR: begin
        cmd_o.clr_occ_last = 1'b1;
        cmd_o.fill_dec     = 1'b1;
      end
      S_SRCH: begin
        cmd_o.res_set = 1'b1;
        if (op_e'(stat_i.op) == OP_READ) begin
          if (stat_i.pos_ge_fill || !stat_i.rocc) begin
            cmd_o.res_status = ST_BAD_POS;
          end else begin
            cmd_o.res_read = 1'b1;
          end
        end else if (!stat_i.idx_lt_fill) begin
          cmd_o.res_status = ST_NOT_FOUND;
        end else if (stat_i.idx_match) begin
          cmd_o.res_found = 1'b1;
        end else begin
          cmd_o.res_set = 1'b0;
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_idx_p1 = 1'b1;
        end
      end
      S_CMP_RD: begin
        if (stat_i.idx_lt_fill) begin
          cmd_o.rd_idx = 1'b1;
        end
      end
      S_CMP_WR: begin
        if (stat_i.rocc) begin
          cmd_o.wr_j_rdata = stat_i.idx_ne_j;
          cmd_o.j_inc      = 1'b1;
        end
        cmd_o.idx_inc = 1'b1;
      end
      S_CLR: begin
        if (stat_i.idx_ne_j) begin
          cmd_o.clr_occ_idx = 1'b1;
          cmd_o.idx_dec     = 1'b1;
        end else begin
          cmd_o.fill_from_j = 1'b1;
          cmd_o.hole_zero   = 1'b1;
          cmd_o.res_set     = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  property p_done_one;
    @(posedge clk_i) disable iff (!rst_ni) state_q == S_DONE |=> state_q == S_IDLE;
  endproperty
  a_done_one: assert property (p_done_one) else $error("done state not left");

  property p_start_decide;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_IDLE && start) |=> state_q == S_DECIDE;
  endproperty
  a_start_decide: assert property (p_start_decide) else $error("accepted item not decoded");

  property p_no_load_busy;
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !cmd_o.load;
  endproperty
  a_no_load_busy: assert property (p_no_load_busy) else $error("load while busy");

endmodule
